@@ hw/rtl/broadcast_discovery_responder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the broadcast discovery responder
// Shared property forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_DISCOVERY_RESPONDER_ASSERT_SVH
`define BROADCAST_DISCOVERY_RESPONDER_ASSERT_SVH

// Same-cycle implication.
`define BDR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in responder logic");

// Next-cycle implication.
`define BDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in responder logic");

`endif

@@ hw/rtl/bdr_pkg.sv @@
// ----------------------------------------------------------------------------
// Broadcast discovery responder package
// Frame geometry, register indexes, shared types and the response template.
// ----------------------------------------------------------------------------
package bdr_pkg;

    // Longest receive frame that is still answered.
    localparam int MAX_FRAME_LENGTH = 127;
    // Counter holds up to MAX_FRAME_LENGTH + 1 (saturation value).
    localparam int CNT_W = $clog2(MAX_FRAME_LENGTH + 2);

    // Response frame length and index width.
    localparam int RESP_LEN   = 21;
    localparam int RESP_IDX_W = $clog2(RESP_LEN);

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_ID    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OWN_SHORT = CFG_IDX_W'(1);
    localparam logic [15:0] PAN_ID_RESET    = 16'hDECA;
    localparam logic [15:0] OWN_SHORT_RESET = 16'h0002;

    // Receive header and payload bytes.
    localparam logic [7:0] FC_LO       = 8'h41;
    localparam logic [7:0] FC_HI_RX    = 8'h88;
    localparam logic [7:0] BCAST_BYTE  = 8'hFF;
    localparam int PAYLOAD_AT  = 9;
    localparam int DISCOV_LEN  = 6;
    localparam int PING_LEN    = 4;
    localparam int MIN_LEN     = 10;

    // Response template bytes.
    localparam logic [7:0] FC_HI_TX    = 8'h8C;
    localparam logic [7:0] TX_PAN_LO   = 8'h9A;
    localparam logic [7:0] TX_PAN_HI   = 8'h60;
    localparam logic [7:0] TX_FUNC     = 8'h10;

    // One response launch from the receive checker to the generator.
    typedef struct packed {
        logic [7:0]  seq;
        logic [15:0] src;
    } launch_t;

    // Expected character of "DISCOV" at a payload offset.
    function automatic logic [7:0] discov_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h44;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h53;
            3'd3:    ch = 8'h43;
            3'd4:    ch = 8'h4F;
            3'd5:    ch = 8'h56;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected character of "PING" at a payload offset.
    function automatic logic [7:0] ping_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h50;
            2'd1:    ch = 8'h49;
            2'd2:    ch = 8'h4E;
            default: ch = 8'h47;
        endcase
        return ch;
    endfunction

    // Response byte at a given position.
    function automatic logic [7:0] resp_byte(input logic [RESP_IDX_W-1:0] idx,
                                             input logic [7:0] seq,
                                             input logic [15:0] src,
                                             input logic [15:0] own);
        logic [7:0] b;
        unique case (idx)
            RESP_IDX_W'(0):  b = FC_LO;
            RESP_IDX_W'(1):  b = FC_HI_TX;
            RESP_IDX_W'(2):  b = seq;
            RESP_IDX_W'(3):  b = TX_PAN_LO;
            RESP_IDX_W'(4):  b = TX_PAN_HI;
            RESP_IDX_W'(5):  b = src[7:0];
            RESP_IDX_W'(6):  b = src[15:8];
            RESP_IDX_W'(13): b = own[7:0];
            RESP_IDX_W'(14): b = own[15:8];
            RESP_IDX_W'(15): b = TX_FUNC;
            default:         b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/bdr_rx_check.sv @@
// ----------------------------------------------------------------------------
// Receive frame checker
// Counts and checks received bytes and launches a response at frame end.
// ----------------------------------------------------------------------------
module bdr_rx_check (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_en,
    input  logic [7:0]      rx_byte,
    input  logic            rx_last,
    input  logic [15:0]     pan_id,
    output logic            launch_valid,
    output bdr_pkg::launch_t launch
);
    import bdr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_FRAME_LENGTH);
    localparam logic [CNT_W-1:0] POS_FC0     = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_FC1     = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_PAN0    = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_PAN1    = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_DST0    = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_DST1    = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_SRC0    = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_SRC1    = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_PAY     = CNT_W'(PAYLOAD_AT);
    localparam logic [CNT_W-1:0] LEN_MIN     = CNT_W'(MIN_LEN);
    localparam logic [CNT_W-1:0] LEN_DISCOV  = CNT_W'(PAYLOAD_AT + DISCOV_LEN);
    localparam logic [CNT_W-1:0] LEN_PING    = CNT_W'(PAYLOAD_AT + PING_LEN);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             header_ok_reg, header_ok_next;
    logic             discov_ok_reg, discov_ok_next;
    logic             ping_ok_reg, ping_ok_next;
    logic [15:0]      source_address_reg, source_address_next;
    logic [7:0]       sequence_number_reg, sequence_number_next;
    logic             launch_valid_reg, launch_valid_next;
    launch_t          launch_reg, launch_next;

    logic             in_range;
    logic             hdr_match;
    logic [CNT_W-1:0] pay_off;
    logic             frame_accept;

    // Per-byte checks against the expected header and payload.
    always_comb begin
        in_range  = (byte_count_reg <= CNT_MAX);
        pay_off   = byte_count_reg - POS_PAY;
        hdr_match = 1'b1;
        if (byte_count_reg == POS_FC0) begin
            hdr_match = (rx_byte == FC_LO);
        end else if (byte_count_reg == POS_FC1) begin
            hdr_match = (rx_byte == FC_HI_RX);
        end else if (byte_count_reg == POS_PAN0) begin
            hdr_match = (rx_byte == pan_id[7:0]);
        end else if (byte_count_reg == POS_PAN1) begin
            hdr_match = (rx_byte == pan_id[15:8]);
        end else if (byte_count_reg == POS_DST0 || byte_count_reg == POS_DST1) begin
            hdr_match = (rx_byte == BCAST_BYTE);
        end

        byte_count_next     = byte_count_reg;
        header_ok_next      = header_ok_reg;
        discov_ok_next      = discov_ok_reg;
        ping_ok_next        = ping_ok_reg;
        source_address_next = source_address_reg;

        if (in_range) begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            header_ok_next  = header_ok_reg & hdr_match;
            if (byte_count_reg == POS_SRC0) begin
                source_address_next = {source_address_reg[15:8], rx_byte};
            end
            if (byte_count_reg == POS_SRC1) begin
                source_address_next = {rx_byte, source_address_reg[7:0]};
            end
            if (byte_count_reg >= POS_PAY && pay_off < CNT_W'(DISCOV_LEN)) begin
                discov_ok_next = discov_ok_reg & (rx_byte == discov_char(pay_off[2:0]));
            end
            if (byte_count_reg >= POS_PAY && pay_off < CNT_W'(PING_LEN)) begin
                ping_ok_next = ping_ok_reg & (rx_byte == ping_char(pay_off[1:0]));
            end
        end
    end

    // Frame decision on the last byte.
    always_comb begin
        frame_accept = (byte_count_next >= LEN_MIN) && (byte_count_next <= CNT_MAX) &&
                       header_ok_next &&
                       ((byte_count_next >= LEN_DISCOV && discov_ok_next) ||
                        (byte_count_next >= LEN_PING && ping_ok_next));
        sequence_number_next = sequence_number_reg;
        launch_valid_next    = 1'b0;
        launch_next          = launch_reg;
        if (byte_en && rx_last && frame_accept) begin
            sequence_number_next = sequence_number_reg + 8'd1;
            launch_valid_next    = 1'b1;
            launch_next.seq      = sequence_number_reg + 8'd1;
            launch_next.src      = source_address_next;
        end
    end

    // Control and frame state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= '0;
            header_ok_reg       <= 1'b1;
            discov_ok_reg       <= 1'b1;
            ping_ok_reg         <= 1'b1;
            source_address_reg  <= '0;
            sequence_number_reg <= '0;
            launch_valid_reg    <= 1'b0;
        end else begin
            launch_valid_reg    <= launch_valid_next;
            sequence_number_reg <= sequence_number_next;
            if (byte_en) begin
                source_address_reg <= source_address_next;
                if (rx_last) begin
                    byte_count_reg <= '0;
                    header_ok_reg  <= 1'b1;
                    discov_ok_reg  <= 1'b1;
                    ping_ok_reg    <= 1'b1;
                end else begin
                    byte_count_reg <= byte_count_next;
                    header_ok_reg  <= header_ok_next;
                    discov_ok_reg  <= discov_ok_next;
                    ping_ok_reg    <= ping_ok_next;
                end
            end
        end
    end

    // Launch payload.
    always_ff @(posedge aclk) begin
        launch_reg <= launch_next;
    end

    assign launch_valid = launch_valid_reg;
    assign launch       = launch_reg;

endmodule

@@ hw/rtl/bdr_tx_gen.sv @@
// ----------------------------------------------------------------------------
// Response generator
// Holds one active and one waiting response and streams the 21 bytes out.
// ----------------------------------------------------------------------------
`include "broadcast_discovery_responder_assert.svh"

module bdr_tx_gen (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             launch_valid,
    input  bdr_pkg::launch_t launch,
    input  logic [15:0]      own_addr,
    output logic             rx_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] tx_byte
    output logic             m_tlast    // tx_last
);
    import bdr_pkg::*;

    localparam logic [RESP_IDX_W-1:0] LAST_IDX = RESP_IDX_W'(RESP_LEN - 1);

    logic                  cur_valid_reg, cur_valid_next;
    launch_t               cur_reg, cur_next;
    logic [RESP_IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    launch_t               pend_reg, pend_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic out_load;
    logic cur_done;

    // Byte sequencing and slot handover.
    always_comb begin
        out_load = cur_valid_reg && (!m_tvalid_reg || m_tready);
        cur_done = out_load && (cur_idx_reg == LAST_IDX);

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = resp_byte(cur_idx_reg, cur_reg.seq, cur_reg.src, own_addr);
            m_tlast_next  = (cur_idx_reg == LAST_IDX);
        end

        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        cur_idx_next    = cur_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (out_load) begin
            cur_idx_next = cur_idx_reg + RESP_IDX_W'(1);
        end
        if (!cur_valid_reg || cur_done) begin
            // Active slot frees up: refill it from the waiting slot or a new launch.
            cur_idx_next = '0;
            if (pend_valid_reg) begin
                cur_valid_next  = 1'b1;
                cur_next        = pend_reg;
                pend_valid_next = 1'b0;
            end else if (launch_valid) begin
                cur_valid_next = 1'b1;
                cur_next       = launch;
            end else begin
                cur_valid_next = 1'b0;
            end
        end else if (launch_valid) begin
            pend_valid_next = 1'b1;
            pend_next       = launch;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg  <= 1'b0;
            cur_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            cur_valid_reg  <= cur_valid_next;
            cur_idx_reg    <= cur_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Receive side stalls only while a response is waiting behind the active one.
    assign rx_ready = !pend_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A launch never meets a full waiting slot.
    `BDR_ASSERT_IMPL(a_no_launch_overrun, launch_valid, !pend_valid_reg)
    // A waiting response always sits behind an active one.
    `BDR_ASSERT_IMPL(a_pend_behind_cur, pend_valid_reg, cur_valid_reg)
    // The final response byte carries the last mark.
    `BDR_ASSERT_NEXT(a_last_marked, cur_done, m_tvalid_reg && m_tlast_reg)

endmodule

@@ hw/rtl/broadcast_discovery_responder.sv @@
// ----------------------------------------------------------------------------
// Broadcast discovery responder
// Checks received broadcast frames and answers DISCOV and PING with a
// 21-byte response frame.
//
//   Channel   Dir   Payload                       Transfer when
//   s_        in    tdata = rx_byte, tlast        s_tvalid & s_tready
//   m_        out   tdata = tx_byte, tlast        m_tvalid & m_tready
//   cfg_      in    cfg_index, cfg_data (16 bit)  cfg_valid & cfg_ready
//
// One received byte is taken per cycle while s_tready is high; checking is
// a single pass per byte. An accepted frame's response passes the launch
// register and the active slot, then leaves the output register one byte
// per cycle while m_tready is high. One response can wait behind the active
// one; s_tready drops only while that waiting slot is occupied. Reset is
// synchronous and needs no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module broadcast_discovery_responder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic                          s_tlast,   // rx_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] tx_byte
    output logic                          m_tlast,   // tx_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import bdr_pkg::*;

    logic [15:0] pan_id_reg;
    logic [15:0] own_short_reg;
    logic        byte_en;
    logic        launch_valid;
    launch_t     launch;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_id_reg    <= PAN_ID_RESET;
            own_short_reg <= OWN_SHORT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_PAN_ID) begin
                pan_id_reg <= cfg_data;
            end
            if (cfg_index == REG_OWN_SHORT) begin
                own_short_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign byte_en   = s_tvalid && s_tready;

    // Receive checker.
    bdr_rx_check u_rx_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .rx_byte      (s_tdata),
        .rx_last      (s_tlast),
        .pan_id       (pan_id_reg),
        .launch_valid (launch_valid),
        .launch       (launch)
    );

    // Response generator.
    bdr_tx_gen u_tx_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .launch_valid (launch_valid),
        .launch       (launch),
        .own_addr     (own_short_reg),
        .rx_ready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Broadcast discovery responder testbench
// Sends received frames byte by byte and predicts every response byte from
// its own copy of the frame checks, the captured source address, the
// sequence number and the two registers. Directed frames cover each header,
// payload and length rule and one long output hold-off, then random traffic
// runs in phases with new register settings and random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import bdr_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int QUIET_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Payload texts, first character in the top byte.
    localparam logic [47:0] DISCOV_TEXT = "DISCOV";
    localparam logic [31:0] PING_TEXT   = "PING";

    // Register indexes that do not exist in the block.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef enum int {
        FRAME_DISCOV,
        FRAME_PING,
        FRAME_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } resp_byte_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
    logic                 s_tlast   = 1'b0; // rx_last
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [7:0]           m_tdata;          // [7:0] tx_byte
    logic                 m_tlast;          // tx_last
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // Predicted receive state and registers.
    int          rx_count      = 0;
    logic        hdr_match     = 1'b1;
    logic        discov_match  = 1'b1;
    logic        ping_match    = 1'b1;
    logic [15:0] peer_address  = '0;
    logic [7:0]  seq_no        = '0;
    logic [15:0] pan_reg       = PAN_ID_RESET;
    logic [15:0] own_reg       = OWN_SHORT_RESET;

    resp_byte_t  resp_expect_q[$];
    logic [7:0]  frame_bytes[$];
    logic [15:0] frame_pan     = PAN_ID_RESET;

    int mismatch_count  = 0;
    int responses_due   = 0;
    int rx_bytes_sent   = 0;
    int cycle_count     = 0;

    // Idling controls shared by the tests, the input side and the output side.
    bit tx_gaps_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    bit hold_req    = 1'b0;
    int stall_left  = 0;

    broadcast_discovery_responder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Reset is held low from the start, then released.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Update the predicted state with one received byte and queue the
    // response bytes when the frame ends and is accepted.
    task automatic track_rx_byte(input logic [7:0] b, input logic last);
        int         pos;
        int         len;
        logic       accept;
        resp_byte_t r;
        pos = rx_count;
        if (pos <= MAX_FRAME_LENGTH) begin
            case (pos)
                0: hdr_match = hdr_match && (b == FC_LO);
                1: hdr_match = hdr_match && (b == FC_HI_RX);
                3: hdr_match = hdr_match && (b == pan_reg[7:0]);
                4: hdr_match = hdr_match && (b == pan_reg[15:8]);
                5, 6: hdr_match = hdr_match && (b == BCAST_BYTE);
                7: peer_address[7:0] = b;
                8: peer_address[15:8] = b;
                default: ;
            endcase
            if (pos >= PAYLOAD_AT && pos < PAYLOAD_AT + DISCOV_LEN)
                discov_match = discov_match &&
                               (b == DISCOV_TEXT[47 - 8 * (pos - PAYLOAD_AT) -: 8]);
            if (pos >= PAYLOAD_AT && pos < PAYLOAD_AT + PING_LEN)
                ping_match = ping_match &&
                             (b == PING_TEXT[31 - 8 * (pos - PAYLOAD_AT) -: 8]);
            rx_count++;
        end
        if (!last) return;

        len = rx_count;
        accept = len >= MIN_LEN && len <= MAX_FRAME_LENGTH && hdr_match &&
                 ((len >= PAYLOAD_AT + DISCOV_LEN && discov_match) ||
                  (len >= PAYLOAD_AT + PING_LEN && ping_match));
        rx_count     = 0;
        hdr_match    = 1'b1;
        discov_match = 1'b1;
        ping_match   = 1'b1;
        if (!accept) return;

        seq_no = seq_no + 8'd1;
        responses_due++;
        for (int k = 0; k < RESP_LEN; k++) begin
            case (k)
                0:  r.data = FC_LO;
                1:  r.data = FC_HI_TX;
                2:  r.data = seq_no;
                3:  r.data = TX_PAN_LO;
                4:  r.data = TX_PAN_HI;
                5:  r.data = peer_address[7:0];
                6:  r.data = peer_address[15:8];
                13: r.data = own_reg[7:0];
                14: r.data = own_reg[15:8];
                15: r.data = TX_FUNC;
                default: r.data = 8'h00;
            endcase
            r.last = (k == RESP_LEN - 1);
            resp_expect_q.push_back(r);
        end
    endtask

    // Compare one response byte with the oldest expected byte.
    task automatic check_tx_byte(input logic [7:0] d, input logic l);
        resp_byte_t e;
        if (resp_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected response byte: data %h last %b", d, l);
        end else begin
            e = resp_expect_q.pop_front();
            if (d !== e.data || l !== e.last) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("response byte mismatch: expected data %h last %b, got data %h last %b",
                             e.data, e.last, d, l);
            end
        end
    endtask

    // Watch every transfer on the three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                track_rx_byte(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PAN_ID)
                    pan_reg = cfg_data;
                else if (cfg_index == REG_OWN_SHORT)
                    own_reg = cfg_data;
            end
            if (m_tvalid && m_tready)
                check_tx_byte(m_tdata, m_tlast);
        end
    end

    // Output side: a random stall after each transfer while rx_stall_on is set,
    // or one long hold-off when a test asks for it.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
                m_tready <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            stall_left = HOLD_CYCLES;
        end else if (aresetn && m_tvalid && m_tready) begin
            stall_left = rx_stall_on ? $urandom_range(0, 9) : 0;
            if (stall_left > 0)
                m_tready <= 1'b0;
        end
    end

    // Offer one received byte and wait for its transfer. tvalid stays high
    // afterwards so that the next byte can follow without a gap.
    task automatic send_rx_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        rx_bytes_sent++;
    endtask

    // Fill frame_bytes with a frame of the given kind and length.
    function automatic void build_frame(input frame_kind_t kind, input int len);
        logic [7:0] b;
        frame_bytes.delete();
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (kind != FRAME_NOISE) begin
                case (i)
                    0: b = FC_LO;
                    1: b = FC_HI_RX;
                    3: b = frame_pan[7:0];
                    4: b = frame_pan[15:8];
                    5, 6: b = BCAST_BYTE;
                    default: ;
                endcase
                if (kind == FRAME_DISCOV && i >= PAYLOAD_AT && i < PAYLOAD_AT + DISCOV_LEN)
                    b = DISCOV_TEXT[47 - 8 * (i - PAYLOAD_AT) -: 8];
                if (kind == FRAME_PING && i >= PAYLOAD_AT && i < PAYLOAD_AT + PING_LEN)
                    b = PING_TEXT[31 - 8 * (i - PAYLOAD_AT) -: 8];
            end
            frame_bytes.push_back(b);
        end
    endfunction

    // Change one byte of the built frame to a different value.
    function automatic void spoil_byte(input int pos);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_rx_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic send_new_frame(input frame_kind_t kind, input int len);
        build_frame(kind, len);
        send_frame();
    endtask

    // Stop offering input, wait for all expected response bytes and let
    // the block settle.
    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (resp_expect_q.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // One register write; call only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_PAN_ID)
            frame_pan = val;
    endtask

    // Frames answered with the registers at their reset values.
    task automatic test_reset_config();
        send_new_frame(FRAME_DISCOV, 15);
        send_new_frame(FRAME_PING, 13);
    endtask

    // Each header, payload and length rule, accepted and rejected.
    task automatic test_frame_rules();
        int hdr_pos[6] = '{0, 1, 3, 4, 5, 6};
        send_new_frame(FRAME_DISCOV, 14);
        send_new_frame(FRAME_PING, 12);
        send_new_frame(FRAME_DISCOV, 13);
        send_new_frame(FRAME_PING, 15);
        send_new_frame(FRAME_PING, 10);
        send_new_frame(FRAME_PING, 9);
        send_new_frame(FRAME_NOISE, 1);
        foreach (hdr_pos[i]) begin
            build_frame(FRAME_DISCOV, 15);
            spoil_byte(hdr_pos[i]);
            send_frame();
        end
        // Byte 2 is not checked, so this frame is still answered.
        build_frame(FRAME_PING, 13);
        spoil_byte(2);
        send_frame();
        // Last character of each payload text wrong.
        build_frame(FRAME_DISCOV, 15);
        spoil_byte(PAYLOAD_AT + DISCOV_LEN - 1);
        send_frame();
        build_frame(FRAME_PING, 13);
        spoil_byte(PAYLOAD_AT + PING_LEN - 1);
        send_frame();
    endtask

    // Longest accepted frame, a too-long frame with the count saturating,
    // and a normal frame afterwards.
    task automatic test_length_limits();
        send_new_frame(FRAME_DISCOV, MAX_FRAME_LENGTH);
        send_new_frame(FRAME_PING, MAX_FRAME_LENGTH + 2);
        send_new_frame(FRAME_PING, 13);
    endtask

    // Register extremes and writes to indexes that do not exist.
    task automatic test_registers();
        logic [15:0] old_pan;
        wait_until_quiet();
        write_reg(REG_PAN_ID, 16'h0000);
        write_reg(REG_OWN_SHORT, 16'hFFFF);
        send_new_frame(FRAME_DISCOV, 15);
        wait_until_quiet();
        old_pan = frame_pan;
        write_reg(REG_PAN_ID, 16'hFFFF);
        write_reg(REG_OWN_SHORT, 16'h0000);
        send_new_frame(FRAME_PING, 13);
        // A frame with the previous PAN identifier is now refused.
        frame_pan = old_pan;
        send_new_frame(FRAME_PING, 13);
        frame_pan = 16'hFFFF;
        wait_until_quiet();
        write_reg(REG_UNUSED_LO, 16'($urandom_range(0, 65535)));
        write_reg(REG_UNUSED_HI, 16'($urandom_range(0, 65535)));
        send_new_frame(FRAME_DISCOV, 16);
        wait_until_quiet();
    endtask

    // Hold the output off while short frames keep arriving, so that the
    // response slots fill and the input stalls.
    task automatic test_back_pressure();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        hold_req    = 1'b1;
        repeat (4) send_new_frame(FRAME_PING, 13);
        wait_until_quiet();
    endtask

    // Random frames in phases, each with new register values, and random idling after the first phase.
    task automatic test_random_traffic();
        int pick;
        int len;
        int bytes_at_start;
        int resp_at_start;
        frame_kind_t kind;
        for (int phase = 0; phase < 3; phase++) begin
            wait_until_quiet();
            write_reg(REG_PAN_ID, 16'($urandom_range(0, 65535)));
            write_reg(REG_OWN_SHORT, 16'($urandom_range(0, 65535)));
            tx_gaps_on  = (phase != 0) && $urandom_range(0, 3) != 0;
            rx_stall_on = (phase != 0) && $urandom_range(0, 3) != 0;
            bytes_at_start = rx_bytes_sent;
            resp_at_start  = responses_due;
            while (rx_bytes_sent - bytes_at_start < 25 || responses_due - resp_at_start < 2) begin
                pick = $urandom_range(0, 99);
                kind = $urandom_range(0, 1) ? FRAME_DISCOV : FRAME_PING;
                if (pick < 45) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(15, 17);
                    send_new_frame(FRAME_DISCOV, len);
                end else if (pick < 75) begin
                    send_new_frame(FRAME_PING, $urandom_range(13, 20));
                end else if (pick < 85) begin
                    len = $urandom_range(13, 20);
                    build_frame(kind, len);
                    spoil_byte($urandom_range(0, 14));
                    send_frame();
                end else if (pick < 93) begin
                    send_new_frame(FRAME_NOISE, $urandom_range(1, 20));
                end else if (pick < 97) begin
                    send_new_frame(kind, $urandom_range(1, 14));
                end else begin
                    send_new_frame(kind, $urandom_range(MAX_FRAME_LENGTH - 7,
                                                        MAX_FRAME_LENGTH + 13));
                end
            end
        end
        wait_until_quiet();
    endtask

    // Test sequence.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        test_reset_config();
        test_frame_rules();
        test_length_limits();
        test_registers();
        test_back_pressure();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bdr_pkg.sv
hw/rtl/bdr_rx_check.sv
hw/rtl/bdr_tx_gen.sv
hw/rtl/broadcast_discovery_responder.sv
tb/tb.sv
